/* rtl/core/ecal_pkg.sv */
// ecal_pkg: shared widths, reciprocal constants, types and the month table
// for the epoch-seconds to calendar converter. No dependencies.
`timescale 1ns / 1ps

package ecal_pkg;

	// payload field widths
	localparam int EPOCH_W = 40;
	localparam int YEAR_W  = 15;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	// pipeline depth, input register to output register
	localparam int NUM_STAGES = 11;

	// seconds to days: 86400 = 2^7 * 675
	localparam int SECS_PER_DAY = 86400;
	localparam int DAY_SHIFT    = 7;
	localparam int DAY_ODD      = SECS_PER_DAY >> DAY_SHIFT;
	localparam int K_DAY        = 42;
	localparam logic [32:0] M_DAY =
		33'(((64'd1 << K_DAY) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

	// days from 0000-03-01 to 1970-01-01
	localparam logic [22:0] DAYS_TO_EPOCH = 23'd719468;

	// 400-year era
	localparam int ERA_DAYS      = 146097;
	localparam int ERA_LAST_DAY  = 146096;
	localparam int YEARS_PER_ERA = 400;
	localparam int K_ERA         = 41;
	localparam logic [23:0] M_ERA =
		24'(((64'd1 << K_ERA) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));

	// time of day
	localparam int SECS_PER_HOUR = 3600;
	localparam int K_HOUR        = 29;
	localparam logic [17:0] M_HOUR =
		18'(((64'd1 << K_HOUR) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
	localparam int SECS_PER_MIN = 60;
	localparam int K_MIN        = 18;
	localparam logic [12:0] M_MIN =
		13'(((64'd1 << K_MIN) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

	// year of era corrections
	localparam int DAYS_4Y_M1 = 1460;
	localparam int K_4Y       = 29;
	localparam logic [18:0] M_4Y =
		19'(((64'd1 << K_4Y) + 64'(DAYS_4Y_M1) - 64'd1) / 64'(DAYS_4Y_M1));
	localparam int DAYS_100Y_M1 = 36524;
	localparam int K_100Y       = 34;
	localparam logic [18:0] M_100Y =
		19'(((64'd1 << K_100Y) + 64'(DAYS_100Y_M1) - 64'd1) / 64'(DAYS_100Y_M1));
	localparam int DAYS_PER_YEAR = 365;
	localparam int K_YEAR        = 27;
	localparam logic [18:0] M_YEAR =
		19'(((64'd1 << K_YEAR) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
	localparam int YEARS_PER_CENT = 100;
	localparam int K_CENT         = 16;
	localparam logic [9:0] M_CENT =
		10'(((64'd1 << K_CENT) + 64'(YEARS_PER_CENT) - 64'd1) / 64'(YEARS_PER_CENT));

	// month from day of shifted year
	localparam int FIVE_MONTH_DAYS = 153;
	localparam int K_MSHIFT        = 19;
	localparam logic [11:0] M_MSHIFT =
		12'(((64'd1 << K_MSHIFT) + 64'(FIVE_MONTH_DAYS) - 64'd1) / 64'(FIVE_MONTH_DAYS));

	// shifted month index of january, month numbers
	localparam logic [3:0] JAN_SHIFTED  = 4'd10;
	localparam logic [3:0] MARCH_OFFSET = 4'd3;
	localparam logic [3:0] JAN_OFFSET   = 4'd9;
	localparam logic [3:0] MONTH_FEB    = 4'd2;

	// stage load enables plus handshake controls
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic                  in_ready;
		logic                  out_valid;
	} ecal_ctrl_t;

	// time of day travelling down the pipe
	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} ecal_tod_t;

	// first day of each shifted month (march is index 0)
	function automatic logic [8:0] month_start(input logic [3:0] ms);
		logic [8:0] r;
		case (ms)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/ecal_in_if.sv */
// ecal_in_if: input channel, valid/ready plus the epoch seconds payload.
// Depends on ecal_pkg.
`timescale 1ns / 1ps

interface ecal_in_if;
	import ecal_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface

/* rtl/core/ecal_out_if.sv */
// ecal_out_if: result channel, valid/ready plus the calendar fields.
// Depends on ecal_pkg.
`timescale 1ns / 1ps

interface ecal_out_if;
	import ecal_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DOM_W-1:0]   day_of_month;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, output ready);
endinterface

/* rtl/core/ecal_pipe_ctrl.sv */
// ecal_pipe_ctrl: per-stage valid bits and load enables for the converter pipe.
// Bubbles collapse; stalls hold full stages with no gap ahead. Uses ecal_pkg.
`timescale 1ns / 1ps

module ecal_pipe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	output ecal_pkg::ecal_ctrl_t ctrl
);
	import ecal_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;
	logic [NUM_STAGES-1:0] vld_nxt;

	// a stage may load unless it and every stage after it are full and stalled
	always_comb begin
		logic full;
		full = 1'b1;
		for (int i = 0; i < NUM_STAGES; i++) begin
			full = 1'b1;
			for (int j = i; j < NUM_STAGES; j++) begin
				full = full & vld_q[j];
			end
			rdy[i] = out_ready | ~full;
		end
	end

	assign vld_nxt = {vld_q[NUM_STAGES-2:0], in_valid};

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_nxt[i];
				end
			end
		end
	end

	assign ctrl.load      = rdy;
	assign ctrl.in_ready  = rdy[0];
	assign ctrl.out_valid = vld_q[NUM_STAGES-1];

endmodule

/* rtl/core/epoch_seconds_to_calendar_top.sv */
// Unix time to UTC calendar date and time of day, eleven-stage pipeline.
// Depends on ecal_pkg, ecal_in_if, ecal_out_if and ecal_pipe_ctrl.
//
// Each transaction on din carries a signed 40-bit count of seconds since
// 1970-01-01T00:00:00Z; a negative count reads as zero. Exactly one
// transaction leaves on dout with year, month, day of month, hour, minute and
// second (proleptic Gregorian, no leap seconds). The pipe takes a new
// transaction every cycle unless all stages are full and dout is stalled;
// each result passes through the 11 register stages, each holding one or
// more constant multiplies or a short add chain. A stalled dout holds its
// result while empty stages behind it keep filling, so up to 11 transactions
// may be in flight. No state survives between transactions and there is
// nothing to configure.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top (
	input logic       clk,
	input logic       arst_n,
	ecal_in_if.sink   din,
	ecal_out_if.source dout
);
	import ecal_pkg::*;

	ecal_ctrl_t            ctrl;
	logic [NUM_STAGES-1:0] ld;

	ecal_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.out_ready(dout.ready),
		.ctrl     (ctrl)
	);

	assign ld        = ctrl.load;
	assign din.ready = ctrl.in_ready;
	assign dout.valid = ctrl.out_valid;

	// stage 1: clamp, split off the power of two, estimate days
	logic [38:0] secs;
	logic [31:0] q0;
	logic [64:0] day_prod;
	logic [22:0] day_s1;
	logic [9:0]  q0lo_s1;
	logic [6:0]  lo7_s1;

	assign secs     = din.epoch_seconds[EPOCH_W-1] ? 39'd0 : din.epoch_seconds[38:0];
	assign q0       = secs[38:DAY_SHIFT];
	assign day_prod = 65'(q0) * 65'(M_DAY);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			day_s1  <= day_prod[K_DAY +: 23];
			q0lo_s1 <= q0[9:0];
			lo7_s1  <= secs[DAY_SHIFT-1:0];
		end
	end

	// stage 2: seconds of day, day count shifted to 0000-03-01
	logic [9:0]  rem_day;
	logic [22:0] shifted_s2;
	logic [16:0] in_day_s2;

	assign rem_day = q0lo_s1 - day_s1[9:0] * 10'(DAY_ODD);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			shifted_s2 <= day_s1 + DAYS_TO_EPOCH;
			in_day_s2  <= {rem_day, lo7_s1};
		end
	end

	// stage 3: era and hour
	logic [46:0] era_prod;
	logic [34:0] hour_prod;
	logic [5:0]  cyc_s3;
	logic [17:0] shlo_s3;
	logic [4:0]  hour_s3;
	logic [11:0] dlo_s3;

	assign era_prod  = 47'(shifted_s2) * 47'(M_ERA);
	assign hour_prod = 35'(in_day_s2) * 35'(M_HOUR);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			cyc_s3  <= era_prod[K_ERA +: 6];
			shlo_s3 <= shifted_s2[17:0];
			hour_s3 <= hour_prod[K_HOUR +: 5];
			dlo_s3  <= in_day_s2[11:0];
		end
	end

	// stage 4: day of era, seconds within the hour
	logic [5:0]  cyc_s4;
	logic [17:0] dic_s4;
	logic [4:0]  hour_s4;
	logic [11:0] rem_h_s4;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			cyc_s4   <= cyc_s3;
			dic_s4   <= shlo_s3 - 18'(cyc_s3) * 18'(ERA_DAYS);
			hour_s4  <= hour_s3;
			rem_h_s4 <= dlo_s3 - 12'(hour_s3) * 12'(SECS_PER_HOUR);
		end
	end

	// stage 5: leap corrections for year of era, minute
	logic [36:0] q4y_prod;
	logic [36:0] q100y_prod;
	logic [24:0] min_prod;
	logic [5:0]  cyc_s5;
	logic [17:0] dic_s5;
	logic [6:0]  q4y_s5;
	logic [2:0]  q100y_s5;
	logic        last_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  minute_s5;
	logic [5:0]  slo_s5;

	assign q4y_prod   = 37'(dic_s4) * 37'(M_4Y);
	assign q100y_prod = 37'(dic_s4) * 37'(M_100Y);
	assign min_prod   = 25'(rem_h_s4) * 25'(M_MIN);

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			cyc_s5    <= cyc_s4;
			dic_s5    <= dic_s4;
			q4y_s5    <= q4y_prod[K_4Y +: 7];
			q100y_s5  <= q100y_prod[K_100Y +: 3];
			last_s5   <= (dic_s4 == 18'(ERA_LAST_DAY));
			hour_s5   <= hour_s4;
			minute_s5 <= min_prod[K_MIN +: 6];
			slo_s5    <= rem_h_s4[5:0];
		end
	end

	// stage 6: corrected day of era, second
	logic [5:0]  cyc_s6;
	logic [17:0] dic_s6;
	logic [17:0] adj_s6;
	ecal_tod_t   tod_s6;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			cyc_s6        <= cyc_s5;
			dic_s6        <= dic_s5;
			adj_s6        <= dic_s5 - 18'(q4y_s5) + 18'(q100y_s5) - 18'(last_s5);
			tod_s6.hour   <= hour_s5;
			tod_s6.minute <= minute_s5;
			tod_s6.second <= slo_s5 - minute_s5 * 6'(SECS_PER_MIN);
		end
	end

	// stage 7: year of era
	logic [36:0] yic_prod;
	logic [5:0]  cyc_s7;
	logic [8:0]  dic_s7;
	logic [8:0]  yic_s7;
	ecal_tod_t   tod_s7;

	assign yic_prod = 37'(adj_s6) * 37'(M_YEAR);

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			cyc_s7 <= cyc_s6;
			dic_s7 <= dic_s6[8:0];
			yic_s7 <= yic_prod[K_YEAR +: 9];
			tod_s7 <= tod_s6;
		end
	end

	// stage 8: centuries within the era
	logic [18:0] cent_prod;
	logic [5:0]  cyc_s8;
	logic [8:0]  dic_s8;
	logic [8:0]  yic_s8;
	logic [1:0]  y100_s8;
	ecal_tod_t   tod_s8;

	assign cent_prod = 19'(yic_s7) * 19'(M_CENT);

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			cyc_s8  <= cyc_s7;
			dic_s8  <= dic_s7;
			yic_s8  <= yic_s7;
			y100_s8 <= cent_prod[K_CENT +: 2];
			tod_s8  <= tod_s7;
		end
	end

	// stage 9: day of shifted year, low bits suffice since it stays below 366
	logic [5:0] cyc_s9;
	logic [8:0] diy_s9;
	logic [8:0] yic_s9;
	ecal_tod_t  tod_s9;

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			cyc_s9 <= cyc_s8;
			diy_s9 <= dic_s8 - (yic_s8 * 9'(DAYS_PER_YEAR) + (yic_s8 >> 2) - 9'(y100_s8));
			yic_s9 <= yic_s8;
			tod_s9 <= tod_s8;
		end
	end

	// stage 10: shifted month
	logic [10:0] ms_num;
	logic [22:0] ms_prod;
	logic [5:0]  cyc_s10;
	logic [8:0]  diy_s10;
	logic [8:0]  yic_s10;
	logic [3:0]  ms_s10;
	ecal_tod_t   tod_s10;

	assign ms_num  = 11'(diy_s9) * 11'd5 + 11'd2;
	assign ms_prod = 23'(ms_num) * 23'(M_MSHIFT);

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			cyc_s10 <= cyc_s9;
			diy_s10 <= diy_s9;
			yic_s10 <= yic_s9;
			ms_s10  <= ms_prod[K_MSHIFT +: 4];
			tod_s10 <= tod_s9;
		end
	end

	// stage 11: civil month, day and year into the output register
	logic [3:0]         mon;
	logic [8:0]         dom_full;
	logic [YEAR_W-1:0]  year_s11;
	logic [MONTH_W-1:0] month_s11;
	logic [DOM_W-1:0]   dom_s11;
	ecal_tod_t          tod_s11;

	assign mon      = (ms_s10 < JAN_SHIFTED) ? ms_s10 + MARCH_OFFSET : ms_s10 - JAN_OFFSET;
	assign dom_full = diy_s10 - month_start(ms_s10) + 9'd1;

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			year_s11  <= YEAR_W'(yic_s10) + YEAR_W'(cyc_s10) * YEAR_W'(YEARS_PER_ERA)
				+ YEAR_W'(mon <= MONTH_FEB);
			month_s11 <= mon;
			dom_s11   <= dom_full[DOM_W-1:0];
			tod_s11   <= tod_s10;
		end
	end

	assign dout.year         = year_s11;
	assign dout.month        = month_s11;
	assign dout.day_of_month = dom_s11;
	assign dout.hour         = tod_s11.hour;
	assign dout.minute       = tod_s11.minute;
	assign dout.second       = tod_s11.second;

endmodule

/* rtl/core/ecal_checker.sv */
// ecal_checker: port-level assertions for the calendar converter, bound to
// epoch_seconds_to_calendar_top. Depends on ecal_pkg.
`timescale 1ns / 1ps

module ecal_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ecal_pkg::YEAR_W-1:0] year,
	input logic [ecal_pkg::MONTH_W-1:0] month,
	input logic [ecal_pkg::DOM_W-1:0]  day_of_month,
	input logic [ecal_pkg::HOUR_W-1:0] hour,
	input logic [ecal_pkg::MIN_W-1:0]  minute,
	input logic [ecal_pkg::SEC_W-1:0]  second
);
	import ecal_pkg::*;

	localparam int CNT_W = $clog2(NUM_STAGES + 2);

	logic [CNT_W-1:0] cnt_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid & in_ready;
	assign out_xfer = out_valid & out_ready;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable({year, month, day_of_month, hour, minute, second}))
		else $error("stalled result changed");

	// fields stay within calendar ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year >= YEAR_W'(1970) && month >= MONTH_W'(1)
		&& month <= MONTH_W'(12) && day_of_month >= DOM_W'(1)
		&& day_of_month <= DOM_W'(31) && hour <= HOUR_W'(23)
		&& minute <= MIN_W'(59) && second <= SEC_W'(59))
		else $error("result field out of range");

	// never more in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_STAGES))
		else $error("too many transactions in flight");

	// no result without a pending transaction
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without a pending transaction");

	// an empty pipe always accepts
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> in_ready)
		else $error("empty pipe refused a transaction");

endmodule

bind epoch_seconds_to_calendar_top ecal_checker u_ecal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.year        (dout.year),
	.month       (dout.month),
	.day_of_month(dout.day_of_month),
	.hour        (dout.hour),
	.minute      (dout.minute),
	.second      (dout.second)
);
